@@ src/ffsa_pkg.sv @@
package ffsa_pkg;

  // Pool geometry fixed by the result field widths.
  localparam int MAX_UNITS     = 4096;
  localparam int UNIT_BYTES    = 65536;
  localparam int UNIT_SHIFT    = $clog2(UNIT_BYTES);
  localparam int START_W       = 12;
  localparam int LEN_W         = 13;
  localparam int END_W         = LEN_W + 1;
  localparam int UNITS_W       = 32 - UNIT_SHIFT + 1;
  localparam int RESET_RECORDS = 6;
  localparam int FRAME_SLOTS_DEFAULT  = 16;
  localparam int REGION_SLOTS_DEFAULT = 32;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_MEM    = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_BAD       = 2'd3
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic {
    CFG_POOL_UNITS   = 1'b0,
    CFG_RECORD_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_APPLY,
    S_REPORT
  } ctrl_state_t;

  typedef struct packed {
    logic    accept;
    logic    step;
    logic    apply;
    logic    fail;
    status_t fail_code;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic    pre_ok;
    status_t pre_code;
    logic    scan_end;
    logic    scan_hit;
    logic    is_free;
    logic    out_free;
  } dp_stat_t;

endpackage

@@ src/ffsa_ctrl.sv @@
module ffsa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ffsa_pkg::dp_stat_t stat,
  output ffsa_pkg::ctrl_cmd_t cmd
);
  import ffsa_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.fail_code = ST_OK;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        // Nothing is taken while reset is held.
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.pre_ok) begin
          cmd.fail = 1'b1;
          cmd.fail_code = stat.pre_code;
          state_next = S_REPORT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_end && !stat.is_free) begin
          // No region is large enough for the request.
          cmd.fail = 1'b1;
          cmd.fail_code = ST_NO_MEM;
          state_next = S_REPORT;
        end else if (stat.scan_end || stat.scan_hit) begin
          state_next = S_APPLY;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = S_REPORT;
      end
      S_REPORT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ src/ffsa_datapath.sv @@
module ffsa_datapath #(
  parameter int FRAME_SLOTS  = ffsa_pkg::FRAME_SLOTS_DEFAULT,
  parameter int REGION_SLOTS = ffsa_pkg::REGION_SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  ffsa_pkg::ctrl_cmd_t cmd,
  output ffsa_pkg::dp_stat_t  stat,
  input  logic                in_op,
  input  logic [3:0]          in_id,
  input  logic [31:0]         in_bytes,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [12:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [11:0]         out_start,
  output logic [12:0]         out_count,
  output logic [28:0]         out_bytes
);
  import ffsa_pkg::*;

  localparam int FIW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int CW  = $clog2(FRAME_SLOTS + 1);
  localparam int RIW = $clog2(REGION_SLOTS);
  localparam int RCW = $clog2(REGION_SLOTS + 1);

  // Free list, sorted by start unit.
  logic [START_W-1:0] fs [REGION_SLOTS];
  logic [LEN_W-1:0]   fl [REGION_SLOTS];
  logic [RCW-1:0]     cnt;

  // Frame records.
  logic               rv [FRAME_SLOTS];
  logic [START_W-1:0] rs [FRAME_SLOTS];
  logic [LEN_W-1:0]   rl [FRAME_SLOTS];
  logic [CW-1:0]      spare, held, lim;

  // Current request.
  logic               op_r;
  logic [3:0]         id_r;
  logic               zero_r;
  logic [UNITS_W-1:0] units_r;

  // Scan state.
  logic [RCW-1:0]     k;
  logic [END_W-1:0]   prev_end;
  logic [LEN_W-1:0]   prev_len;

  // Result.
  status_t            res_status;
  logic [START_W-1:0] res_start;
  logic [LEN_W-1:0]   res_count;

  logic [FIW-1:0]     id_idx;
  logic [RIW-1:0]     k_idx, km1_idx;
  logic [START_W-1:0] e_s, rec_s;
  logic [LEN_W-1:0]   e_l, rec_n, new_len;
  logic               id_ok, rec_valid;
  logic [END_W-1:0]   rec_end;
  logic               jp, jn;

  // Table update decode.
  logic               tbl_we, tbl_wr_s, shl, shr, cnt_dec, cnt_inc, app_ok;
  logic [RIW-1:0]     tbl_idx;
  logic [START_W-1:0] tbl_s;
  logic [LEN_W-1:0]   tbl_l;

  logic [CW-1:0]      lim_w;
  logic [LEN_W-1:0]   pool_w;

  assign id_idx  = FIW'(id_r);
  assign id_ok   = 32'(id_r) < 32'(FRAME_SLOTS);
  assign rec_valid = id_ok ? rv[id_idx] : 1'b0;
  assign rec_s   = rs[id_idx];
  assign rec_n   = rl[id_idx];
  assign rec_end = END_W'(rec_s) + END_W'(rec_n);
  assign k_idx   = k[RIW-1:0];
  assign km1_idx = k_idx - 1'b1;
  assign e_s     = fs[k_idx];
  assign e_l     = fl[k_idx];
  assign new_len = e_l - LEN_W'(units_r);

  assign jp = (k != '0) && (prev_end == END_W'(rec_s));
  assign jn = (k < cnt) && (rec_end == END_W'(e_s));

  always_comb begin
    stat.pre_ok   = 1'b1;
    stat.pre_code = ST_OK;
    if (!id_ok) begin
      stat.pre_ok   = 1'b0;
      stat.pre_code = ST_BAD;
    end else if (op_r == OP_ALLOC) begin
      if (zero_r || rec_valid) begin
        stat.pre_ok   = 1'b0;
        stat.pre_code = ST_BAD;
      end else if (spare == '0) begin
        stat.pre_ok   = 1'b0;
        stat.pre_code = ST_NO_MEM;
      end
    end else if (!rec_valid) begin
      stat.pre_ok   = 1'b0;
      stat.pre_code = ST_NOT_ALLOC;
    end
    stat.scan_end = (k >= cnt);
    stat.scan_hit = (op_r == OP_ALLOC) ? (UNITS_W'(e_l) >= units_r) : (e_s > rec_s);
    stat.is_free  = (op_r == OP_FREE);
    stat.out_free = !out_valid || out_ready;
  end

  always_comb begin
    tbl_we = 1'b0; tbl_wr_s = 1'b0; shl = 1'b0; shr = 1'b0;
    cnt_dec = 1'b0; cnt_inc = 1'b0; app_ok = 1'b1;
    tbl_idx = k_idx; tbl_s = rec_s; tbl_l = rec_n;
    if (op_r == OP_ALLOC) begin
      if (new_len == '0) begin
        shl = 1'b1;
        cnt_dec = 1'b1;
      end else begin
        tbl_we = 1'b1; tbl_wr_s = 1'b1;
        tbl_s = e_s + START_W'(units_r);
        tbl_l = new_len;
      end
    end else if (jp && jn) begin
      tbl_we = 1'b1; tbl_idx = km1_idx;
      tbl_l = prev_len + rec_n + e_l;
      shl = 1'b1; cnt_dec = 1'b1;
    end else if (jp) begin
      tbl_we = 1'b1; tbl_idx = km1_idx;
      tbl_l = prev_len + rec_n;
    end else if (jn) begin
      tbl_we = 1'b1; tbl_wr_s = 1'b1;
      tbl_l = e_l + rec_n;
    end else if (32'(cnt) >= 32'(REGION_SLOTS)) begin
      app_ok = 1'b0;
    end else begin
      tbl_we = 1'b1; tbl_wr_s = 1'b1;
      shr = 1'b1; cnt_inc = 1'b1;
    end
  end

  assign lim_w  = (32'(cfg_data[4:0]) > 32'(FRAME_SLOTS)) ? CW'(FRAME_SLOTS)
                                                         : CW'(cfg_data[4:0]);
  assign pool_w = (32'(cfg_data) > 32'(MAX_UNITS)) ? LEN_W'(MAX_UNITS) : cfg_data;

  // Control state: counts, valid bits, limits, output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      lim   <= CW'((RESET_RECORDS > FRAME_SLOTS) ? FRAME_SLOTS : RESET_RECORDS);
      spare <= CW'((RESET_RECORDS > FRAME_SLOTS) ? FRAME_SLOTS : RESET_RECORDS);
      held  <= '0;
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        rv[i] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we && cfg_index == CFG_POOL_UNITS) begin
        cnt   <= (pool_w != '0) ? RCW'(1) : '0;
        spare <= lim;
        held  <= '0;
        for (int i = 0; i < FRAME_SLOTS; i++) begin
          rv[i] <= 1'b0;
        end
      end else if (cfg_we && cfg_index == CFG_RECORD_LIMIT) begin
        lim   <= lim_w;
        spare <= (lim_w > held) ? lim_w - held : '0;
      end else if (cmd.apply && app_ok) begin
        if (cnt_dec) begin
          cnt <= cnt - 1'b1;
        end else if (cnt_inc) begin
          cnt <= cnt + 1'b1;
        end
        if (op_r == OP_ALLOC) begin
          rv[id_idx] <= 1'b1;
          spare <= spare - 1'b1;
          held  <= held + 1'b1;
        end else begin
          rv[id_idx] <= 1'b0;
          spare <= spare + 1'b1;
          held  <= held - 1'b1;
        end
      end
    end
  end

  // Payload: tables, request, scan registers, results.
  always_ff @(posedge clk) begin
    if (cfg_we && cfg_index == CFG_POOL_UNITS) begin
      fs[0] <= '0;
      fl[0] <= pool_w;
    end else if (cmd.apply && app_ok) begin
      if (shl) begin
        for (int i = 0; i < REGION_SLOTS - 1; i++) begin
          if (i >= int'(k)) begin
            fs[i] <= fs[i+1];
            fl[i] <= fl[i+1];
          end
        end
      end
      if (shr) begin
        for (int i = 1; i < REGION_SLOTS; i++) begin
          if (i > int'(k)) begin
            fs[i] <= fs[i-1];
            fl[i] <= fl[i-1];
          end
        end
      end
      if (tbl_we) begin
        fl[tbl_idx] <= tbl_l;
        if (tbl_wr_s) begin
          fs[tbl_idx] <= tbl_s;
        end
      end
      if (op_r == OP_ALLOC) begin
        rs[id_idx] <= e_s;
        rl[id_idx] <= LEN_W'(units_r);
      end
    end

    if (cmd.accept) begin
      op_r    <= in_op;
      id_r    <= in_id;
      zero_r  <= (in_bytes == '0);
      units_r <= UNITS_W'(in_bytes >> UNIT_SHIFT) +
                 UNITS_W'(in_bytes[UNIT_SHIFT-1:0] != '0);
      k       <= '0;
    end else if (cmd.step) begin
      k        <= k + 1'b1;
      prev_end <= END_W'(e_s) + END_W'(e_l);
      prev_len <= e_l;
    end

    if (cmd.fail) begin
      res_status <= cmd.fail_code;
      res_start  <= '0;
      res_count  <= '0;
    end else if (cmd.apply) begin
      if (!app_ok) begin
        res_status <= ST_NO_MEM;
        res_start  <= '0;
        res_count  <= '0;
      end else begin
        res_status <= ST_OK;
        res_start  <= (op_r == OP_ALLOC) ? e_s : rec_s;
        res_count  <= (op_r == OP_ALLOC) ? LEN_W'(units_r) : rec_n;
      end
    end

    if (cmd.load_out) begin
      out_status <= res_status;
      out_start  <= res_start;
      out_count  <= res_count;
      out_bytes  <= {res_count[12:0], 16'd0};
    end
  end

endmodule

@@ src/first_fit_segment_allocator_core.sv @@
// First-fit segment allocator over a pool of 64 KiB units.
// Requests arrive on the s_* stream: s_tuser holds the operation (allocate
// or free) and s_tdata holds the frame id and the request size in bytes.
// Every accepted transfer produces exactly one result transfer on the m_*
// stream with a status, the start unit, the unit count and the size in
// bytes. The cfg_* port writes the pool size (index 0), which rebuilds the
// pool as one free region and drops all records, and the record limit
// (index 1). Write configuration only while no request is in flight.
// A request that the first check rejects goes straight to the report; an
// allocation that finds no fitting region goes to the report from the scan,
// and a grant or a free passes through the scan and the update first. The
// first-fit scan steps over at most REGION_SLOTS free-list entries, and
// it reads one entry per cycle.
// Splitting, merging and list shifts are all done in the update state. The
// next request can be taken in the cycle after the result is loaded.
// One request is worked on at a time; a new one is taken once the previous
// result sits in the output register, so a stalled receiver holds at most
// one finished result while one more request proceeds up to the report.
// Synchronous reset empties the pool, clears every record and sets the
// record limit to six; no clearing pass is needed.
module first_fit_segment_allocator_core #(
  parameter int FRAME_SLOTS  = ffsa_pkg::FRAME_SLOTS_DEFAULT,
  parameter int REGION_SLOTS = ffsa_pkg::REGION_SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // frame_id[3:0], request_bytes[35:4], zero pad
  input  logic [0:0]  s_tuser,   // operation[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // status[1:0], start_unit[13:2],
                                 // unit_count[26:14], granted_bytes[55:27]
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import ffsa_pkg::*;

  ctrl_cmd_t   cmd;
  dp_stat_t    stat;
  logic [1:0]  out_status;
  logic [11:0] out_start;
  logic [12:0] out_count;
  logic [28:0] out_bytes;

  // The controller sequences check, scan, update and report.
  ffsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath owns the free list, the records and the result register.
  ffsa_datapath #(
    .FRAME_SLOTS  (FRAME_SLOTS),
    .REGION_SLOTS (REGION_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (s_tuser[0]),
    .in_id      (s_tdata[3:0]),
    .in_bytes   (s_tdata[35:4]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index[0]),
    .cfg_data   (cfg_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_start  (out_start),
    .out_count  (out_count),
    .out_bytes  (out_bytes)
  );

  assign m_tdata = {out_bytes, out_count, out_start, out_status};

endmodule

@@ dv/first_fit_segment_allocator_core_tb.sv @@
module first_fit_segment_allocator_core_tb;
  import ffsa_pkg::*;

  // One result transfer, unpacked from m_tdata.
  typedef struct {
    status_t     status;
    logic [11:0] start_unit;
    logic [12:0] unit_count;
    logic [28:0] granted_bytes;
  } grant_t;

  // A row of the directed table: either a register write or a request.
  // Rows with a typed grant are checked against that value; the rest
  // are checked against the allocator model below.
  typedef struct {
    bit          is_cfg;
    cfg_idx_t    reg_idx;
    int          reg_value;
    op_t         op;
    int          frame;
    logic [31:0] req_bytes;
    bit          typed;
    grant_t      grant;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // frame_id[3:0], request_bytes[35:4], zero pad
  logic [0:0]  s_tuser;   // operation[0]
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;   // status, start_unit, unit_count, granted_bytes
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [12:0] cfg_data;

  first_fit_segment_allocator_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // Model of the allocator: address-sorted free regions plus frame records.
  int pool_size;
  int frame_limit;
  int region_base[32];
  int region_len[32];
  int region_total;
  bit frame_held[16];
  int frame_base[16];
  int frame_len[16];
  int spare_frames;

  grant_t pending_grants[$];
  int     mismatches;
  int     idle_cycles;
  bit     long_hold_req;

  function automatic int clamp_limit();
    return (frame_limit > 16) ? 16 : frame_limit;
  endfunction

  function automatic void rebuild_pool();
    region_total = 0;
    if (pool_size > 0) begin
      region_base[0] = 0;
      region_len[0]  = (pool_size > MAX_UNITS) ? MAX_UNITS : pool_size;
      region_total   = 1;
    end
    for (int i = 0; i < 16; i++) frame_held[i] = 1'b0;
    spare_frames = clamp_limit();
  endfunction

  function automatic void write_register(cfg_idx_t idx, int value);
    int held;
    held = 0;
    if (idx == CFG_POOL_UNITS) begin
      pool_size = value & 'h1FFF;
      rebuild_pool();
    end else begin
      frame_limit = value & 'h1F;
      for (int i = 0; i < 16; i++) held += frame_held[i];
      spare_frames = (clamp_limit() > held) ? clamp_limit() - held : 0;
    end
  endfunction

  function automatic void drop_region(int k);
    for (int i = k; i + 1 < region_total; i++) begin
      region_base[i] = region_base[i + 1];
      region_len[i]  = region_len[i + 1];
    end
    region_total--;
  endfunction

  // Works out the grant for one request and updates the model state.
  function automatic grant_t allocate_or_release(op_t op, int frame, logic [31:0] req_bytes);
    grant_t g;
    longint units;
    int     k;
    int     base;
    int     len;
    bit     join_lo;
    bit     join_hi;
    g = '{ST_OK, '0, '0, '0};
    if (op == OP_ALLOC) begin
      units = (longint'(req_bytes) + UNIT_BYTES - 1) / UNIT_BYTES;
      if (req_bytes == 0 || frame_held[frame]) begin
        g.status = ST_BAD;
      end else if (spare_frames == 0) begin
        g.status = ST_NO_MEM;
      end else begin
        for (k = 0; k < region_total; k++)
          if (region_len[k] >= units) break;
        if (k >= region_total) begin
          g.status = ST_NO_MEM;
        end else begin
          base = region_base[k];
          region_base[k] += int'(units);
          region_len[k]  -= int'(units);
          if (region_len[k] == 0) drop_region(k);
          frame_held[frame] = 1'b1;
          frame_base[frame] = base;
          frame_len[frame]  = int'(units);
          spare_frames--;
          g.start_unit = 12'(base);
          g.unit_count = 13'(units);
        end
      end
    end else if (!frame_held[frame]) begin
      g.status = ST_NOT_ALLOC;
    end else begin
      base = frame_base[frame];
      len  = frame_len[frame];
      for (k = 0; k < region_total; k++)
        if (region_base[k] > base) break;
      join_lo = k > 0 && region_base[k - 1] + region_len[k - 1] == base;
      join_hi = k < region_total && base + len == region_base[k];
      if (join_lo && join_hi) begin
        region_len[k - 1] += len + region_len[k];
        drop_region(k);
      end else if (join_lo) begin
        region_len[k - 1] += len;
      end else if (join_hi) begin
        region_base[k] = base;
        region_len[k] += len;
      end else if (region_total >= 32) begin
        g.status = ST_NO_MEM;
      end else begin
        for (int i = region_total; i > k; i--) begin
          region_base[i] = region_base[i - 1];
          region_len[i]  = region_len[i - 1];
        end
        region_base[k] = base;
        region_len[k]  = len;
        region_total++;
      end
      if (g.status == ST_OK) begin
        frame_held[frame] = 1'b0;
        spare_frames++;
        g.start_unit = 12'(base);
        g.unit_count = 13'(len);
      end
    end
    g.granted_bytes = {g.unit_count, 16'd0};
    return g;
  endfunction

  // Sends one request; valid stays high across back-to-back transfers.
  task automatic send_request(op_t op, int frame, logic [31:0] req_bytes, bit typed,
                              grant_t grant, int gap);
    grant_t g;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'd0, req_bytes, 4'(frame)};
    do @(posedge clk); while (!s_tready);
    g = allocate_or_release(op, frame, req_bytes);
    pending_grants.push_back(typed ? grant : g);
  endtask

  // Register writes go in only once every result is back and the core idles.
  task automatic program_register(cfg_idx_t idx, int value);
    s_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 13'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    write_register(idx, value);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic row_t req_row(op_t op, int frame, logic [31:0] b, bit typed, grant_t g);
    return '{1'b0, CFG_POOL_UNITS, 0, op, frame, b, typed, g};
  endfunction

  function automatic row_t cfg_row(cfg_idx_t idx, int value);
    return '{1'b1, idx, value, OP_ALLOC, 0, '0, 1'b0, '{ST_OK, '0, '0, '0}};
  endfunction

  // Result side: random back-pressure, plus one long hold-off on request
  // so the core fills up and has to drop s_tready.
  initial begin
    int span;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      span = pick_gap();
      if (span > 0) begin
        m_tready <= 1'b0;
        repeat (span) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Every result transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    grant_t want;
    grant_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status        = status_t'(m_tdata[1:0]);
      got.start_unit    = m_tdata[13:2];
      got.unit_count    = m_tdata[26:14];
      got.granted_bytes = m_tdata[55:27];
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", m_tdata);
      end else begin
        want = pending_grants.pop_front();
        if (got.status !== want.status || got.start_unit !== want.start_unit ||
            got.unit_count !== want.unit_count ||
            got.granted_bytes !== want.granted_bytes) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected st=%0d start=%0d cnt=%0d bytes=%0d, ",
                      "got st=%0d start=%0d cnt=%0d bytes=%0d"},
                     want.status, want.start_unit, want.unit_count, want.granted_bytes,
                     got.status, got.start_unit, got.unit_count, got.granted_bytes);
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 6000) begin
        $display("first_fit_segment_allocator_core_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    row_t   rows[$];
    grant_t none;
    int     span;
    int     frame;
    longint units;
    logic [31:0] b;
    none          = '{ST_OK, '0, '0, '0};
    mismatches    = 0;
    idle_cycles   = 0;
    long_hold_req = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    pool_size   = 0;
    frame_limit = RESET_RECORDS;
    rebuild_pool();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. After reset the pool is empty, so nothing fits.
    rows.push_back(req_row(OP_ALLOC, 0, 100, 1, '{ST_NO_MEM, 0, 0, 0}));
    rows.push_back(req_row(OP_FREE, 0, 0, 1, '{ST_NOT_ALLOC, 0, 0, 0}));
    // An oversized pool saturates to the full 4096 units.
    rows.push_back(cfg_row(CFG_POOL_UNITS, 8191));
    rows.push_back(req_row(OP_ALLOC, 0, 0, 1, '{ST_BAD, 0, 0, 0}));
    rows.push_back(req_row(OP_ALLOC, 0, 1, 1, '{ST_OK, 0, 1, 65536}));
    rows.push_back(req_row(OP_ALLOC, 0, 5, 1, '{ST_BAD, 0, 0, 0}));
    rows.push_back(req_row(OP_ALLOC, 15, 32'hFFFF_FFFF, 1, '{ST_NO_MEM, 0, 0, 0}));
    rows.push_back(req_row(OP_ALLOC, 1, 65536, 0, none));
    rows.push_back(req_row(OP_ALLOC, 2, 65537, 0, none));
    // Frees that merge with no neighbor, the next one, then both sides.
    rows.push_back(req_row(OP_FREE, 1, 0, 0, none));
    rows.push_back(req_row(OP_FREE, 0, 0, 0, none));
    rows.push_back(req_row(OP_FREE, 2, 0, 0, none));
    // A zero record limit leaves no spare record.
    rows.push_back(cfg_row(CFG_RECORD_LIMIT, 0));
    rows.push_back(req_row(OP_ALLOC, 3, 100, 1, '{ST_NO_MEM, 0, 0, 0}));
    rows.push_back(cfg_row(CFG_RECORD_LIMIT, 31));
    rows.push_back(req_row(OP_ALLOC, 4, 32'h0FFF_0000, 0, none));
    rows.push_back(req_row(OP_ALLOC, 5, 32'h0002_0000, 1, '{ST_NO_MEM, 0, 0, 0}));
    rows.push_back(req_row(OP_ALLOC, 5, 32'h0001_0000, 0, none));
    rows.push_back(req_row(OP_FREE, 5, 0, 0, none));
    rows.push_back(req_row(OP_FREE, 4, 0, 0, none));
    // A zero pool gives an empty free list.
    rows.push_back(cfg_row(CFG_POOL_UNITS, 0));
    rows.push_back(req_row(OP_ALLOC, 6, 32'h8000_0000, 1, '{ST_NO_MEM, 0, 0, 0}));
    foreach (rows[i]) begin
      if (rows[i].is_cfg)
        program_register(rows[i].reg_idx, rows[i].reg_value);
      else
        send_request(rows[i].op, rows[i].frame, rows[i].req_bytes, rows[i].typed,
                     rows[i].grant, pick_gap());
    end

    // Random part: phases with fresh settings, mostly small pools so that
    // the free list fragments, with the extremes mixed in.
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: program_register(CFG_POOL_UNITS, 4096);
        1: program_register(CFG_POOL_UNITS, 1);
        2: program_register(CFG_POOL_UNITS, 8191);
        default: program_register(CFG_POOL_UNITS, $urandom_range(8, 80));
      endcase
      if (phase % 3 == 2) program_register(CFG_RECORD_LIMIT, $urandom_range(0, 31));
      else                program_register(CFG_RECORD_LIMIT, $urandom_range(4, 16));
      if (phase == 1) long_hold_req = 1'b1;
      for (int n = 0; n < 115; n++) begin
        frame = $urandom_range(0, 15);
        span  = ($urandom_range(0, 4) == 0) ? 0 : pick_gap();
        if ($urandom_range(0, 99) < 55) begin
          if ($urandom_range(0, 4) == 0) begin
            b = $urandom;
          end else begin
            units = $urandom_range(1, (pool_size > 24) ? pool_size / 6 : 4);
            b = 32'(units * UNIT_BYTES) - 32'($urandom_range(0, 65535));
          end
          send_request(OP_ALLOC, frame, b, 0, none, span);
        end else begin
          send_request(OP_FREE, frame, $urandom, 0, none, span);
        end
        // A mid-phase limit change keeps the held records.
        if (n == 60 && phase % 2 == 1)
          program_register(CFG_RECORD_LIMIT, $urandom_range(0, 31));
      end
    end

    s_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0)
      $display("first_fit_segment_allocator_core_tb OK");
    else
      $display("first_fit_segment_allocator_core_tb NOT OK");
    $finish;
  end

endmodule
